>>> hdl/sse_pkg.sv
// Shared constants, codes and helpers for the two-state Euler state-space block.
// Holds field widths, status and register codes, coefficient unpacking and saturation.
// No dependencies.
package sse_pkg;

  // Model dimensions, fixed for this block
  localparam int unsigned NUM_STATES  = 2;
  localparam int unsigned NUM_INPUTS  = 2;
  localparam int unsigned NUM_OUTPUTS = 2;

  // Field widths
  localparam int unsigned COEF_W     = 16;  // Q4.12 coefficient
  localparam int unsigned U_W        = 16;  // Q4.12 input
  localparam int unsigned DT_W       = 16;  // Q0.16 time step
  localparam int unsigned X_W        = 32;  // Q16.16 state and output
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Datapath widths
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 56;
  localparam int unsigned XD_W    = 49;  // A*x + B*u at Q.28
  localparam int unsigned DET_W   = 33;  // det(A) at Q.24
  localparam int unsigned V_W     = 33;  // B*u at Q.24
  localparam int unsigned W_W     = 49;  // adj(A)*B*u at Q.36
  localparam int unsigned DEN_W   = 32;  // |det|
  localparam int unsigned DIV_W   = W_W + 4;
  localparam int unsigned CNT_W   = $clog2(DIV_W);

  // Rounding offsets at the accumulator width
  localparam logic signed [ACC_W-1:0] Y_BIAS   = ACC_W'(2048);       // half LSB of Q.16 from Q.28
  localparam logic signed [ACC_W-1:0] INC_BIAS = ACC_W'(134217728);  // half LSB of Q.16 from Q.44

  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SINGULAR  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A = 3'd0,
    CFG_B = 3'd1,
    CFG_C = 3'd2,
    CFG_D = 3'd3
  } cfg_idx_e;

  // Entry k of a packed row-major 2x2 matrix
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_DATA_W-1:0] mat,
                                                       input logic [1:0] k);
    return mat[{k, 4'b0000} +: COEF_W];
  endfunction

  // Clip to 32 bits; the top bit of the result flags a clip
  function automatic logic [X_W:0] sat32(input logic signed [63:0] v);
    logic [X_W:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = {1'b1, 32'h7fff_ffff};
    else if (v < 64'shffff_ffff_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[X_W-1:0]};
    return r;
  endfunction

endpackage

>>> hdl/state_space_euler_step.sv
// Two-state linear state-space block: y = C*x + D*u, then forward Euler x += dt*(A*x + B*u).
// Step beat: the shared 17x33 multiply-accumulate runs 20 products, each through a MUL and
// an ACC state, plus a FIN state per row; no new request is taken until the result has loaded.
// Init beat: det(A) == 0 ends after the det(A) row; otherwise the radix-2 divider runs
// 53 quotient steps per state.
// Async active-low reset clears the state vector, the coefficient registers and all control.
module state_space_euler_step import sse_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // Request beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic signed [U_W-1:0]        u_first_i,
  input  logic signed [U_W-1:0]        u_second_i,
  input  logic [DT_W-1:0]              dt_i,
  // Result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [X_W-1:0]        y_first_o,
  output logic signed [X_W-1:0]        y_second_o,
  output logic signed [X_W-1:0]        x_first_o,
  output logic signed [X_W-1:0]        x_second_o,
  output logic [STATUS_W-1:0]          status_o
);

  // Sequencer: each multiply term passes through MUL then ACC, each row ends in FIN.
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_FIN, S_DSTART, S_DIV, S_DFIN, S_DONE
  } state_e;

  // Rows of work. Step: Y0..INC1. Init: DET..W1, then two divides.
  typedef enum logic [3:0] {
    PH_Y0, PH_Y1, PH_XD0, PH_INC0, PH_XD1, PH_INC1,
    PH_DET, PH_V0, PH_V1, PH_W0, PH_W1
  } phase_e;

  state_e                    state_q;
  phase_e                    phase_q;
  logic [1:0]                term_q;
  logic                      row_q;
  logic [CNT_W-1:0]          cnt_q;

  logic [CFG_DATA_W-1:0]     a_q, b_q, c_q, d_q;
  logic signed [X_W-1:0]     x_q [NUM_STATES];

  logic                      out_valid_q;
  logic signed [X_W-1:0]     yo_q [2];
  logic signed [X_W-1:0]     xo_q [NUM_STATES];
  logic [STATUS_W-1:0]       st_q;

  // Datapath registers
  logic                      req_q;
  logic signed [U_W-1:0]     u0_q, u1_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [XD_W-1:0]    xd_q;
  logic signed [DET_W-1:0]   det_q;
  logic signed [V_W-1:0]     v_q [2];
  logic signed [W_W-1:0]     w_q [2];
  logic signed [X_W-1:0]     y_q [2];
  logic signed [X_W-1:0]     xn_q [NUM_STATES];
  logic                      clip_q, sing_q;
  logic [DIV_W-1:0]          qd_q;
  logic [DEN_W-1:0]          rem_q, den_q;
  logic                      neg_q;

  logic in_accept, out_take, out_free, load_out;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == S_DONE) && out_free;

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      shift4, negate, rnd16;
  logic [CFG_DATA_W-1:0]     mat_x, mat_u;
  logic                      mrow;
  logic [1:0]                last_term;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    shift4    = 1'b0;
    negate    = 1'b0;
    rnd16     = 1'b0;
    mrow      = (phase_q == PH_Y1) || (phase_q == PH_XD1);
    mat_x     = ((phase_q == PH_Y0) || (phase_q == PH_Y1)) ? c_q : a_q;
    mat_u     = ((phase_q == PH_Y0) || (phase_q == PH_Y1)) ? d_q : b_q;
    last_term = 2'd1;
    unique case (phase_q) inside
      PH_Y0, PH_Y1, PH_XD0, PH_XD1: begin
        last_term = 2'd3;
        case (term_q)
          2'd0: begin
            mul_a = MUL_A_W'(coef_at(mat_x, {mrow, 1'b0}));
            mul_b = MUL_B_W'(x_q[0]);
          end
          2'd1: begin
            mul_a = MUL_A_W'(coef_at(mat_x, {mrow, 1'b1}));
            mul_b = MUL_B_W'(x_q[1]);
          end
          2'd2: begin
            mul_a  = MUL_A_W'(coef_at(mat_u, {mrow, 1'b0}));
            mul_b  = MUL_B_W'(u0_q);
            shift4 = 1'b1;
          end
          default: begin
            // second input drops out of a one-input model
            mul_a  = (NUM_INPUTS > 1) ? MUL_A_W'(coef_at(mat_u, {mrow, 1'b1})) : '0;
            mul_b  = MUL_B_W'(u1_q);
            shift4 = 1'b1;
          end
        endcase
        // second output reads zero in a one-output model
        if ((phase_q == PH_Y1) && (NUM_OUTPUTS < 2)) mul_a = '0;
      end
      PH_INC0, PH_INC1: begin
        mul_a = MUL_A_W'({1'b0, dt_q});
        if (term_q == 2'd0) begin
          mul_b = MUL_B_W'({1'b0, xd_q[15:0]});
          rnd16 = 1'b1;
        end else begin
          mul_b = xd_q[XD_W-1:16];
        end
      end
      PH_DET: begin
        mul_a  = MUL_A_W'(coef_at(a_q, (term_q == 2'd0) ? 2'd0 : 2'd1));
        mul_b  = MUL_B_W'(coef_at(a_q, (term_q == 2'd0) ? 2'd3 : 2'd2));
        negate = (term_q != 2'd0);
      end
      PH_V0, PH_V1: begin
        mul_a = MUL_A_W'(coef_at(b_q, {(phase_q == PH_V1), term_q[0]}));
        mul_b = (term_q == 2'd0) ? MUL_B_W'(u0_q) : MUL_B_W'(u1_q);
      end
      PH_W0: begin
        mul_a  = MUL_A_W'(coef_at(a_q, (term_q == 2'd0) ? 2'd3 : 2'd1));
        mul_b  = (term_q == 2'd0) ? v_q[0] : v_q[1];
        negate = (term_q != 2'd0);
      end
      default: begin
        // PH_W1: a00*v1 - a10*v0
        mul_a  = MUL_A_W'(coef_at(a_q, (term_q == 2'd0) ? 2'd0 : 2'd2));
        mul_b  = (term_q == 2'd0) ? v_q[1] : v_q[0];
        negate = (term_q != 2'd0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Multiply, accumulate and row finish arithmetic
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] mul_res;
  logic signed [ACC_W-1:0]  prod_ext, term_ext, acc_base, acc_d;
  logic signed [ACC_W-1:0]  y_rnd, inc_val;
  logic signed [63:0]       x_sum;
  logic [X_W:0]             y_sat, x_sat;
  logic                     inc_row;

  assign mul_res  = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_q);
  assign term_ext = shift4 ? (prod_ext <<< 4) : prod_ext;
  assign acc_base = (term_q == 2'd0) ? '0 : acc_q;

  always_comb begin
    if (rnd16) acc_d = (prod_ext + INC_BIAS) >>> 16;
    else if (negate) acc_d = acc_base - term_ext;
    else acc_d = acc_base + term_ext;
  end

  assign y_rnd   = (acc_q + Y_BIAS) >>> 12;
  assign y_sat   = sat32(64'(y_rnd));
  assign inc_row = (phase_q == PH_INC1);
  assign inc_val = acc_q >>> 12;
  assign x_sum   = 64'(inc_val) + 64'(x_q[inc_row]);
  assign x_sat   = sat32(x_sum);

  // Divider setup: |16*w| + |det|/2 over |det|, sign applied at the end
  logic signed [W_W-1:0]   w_sel;
  logic [W_W-1:0]          w_abs;
  logic [DET_W-1:0]        den_abs;
  logic [DIV_W-1:0]        dividend;
  logic                    div_neg;

  assign w_sel    = w_q[row_q];
  assign w_abs    = w_sel[W_W-1] ? W_W'(-w_sel) : w_sel;
  assign den_abs  = det_q[DET_W-1] ? DET_W'(-det_q) : det_q;
  assign dividend = DIV_W'({w_abs, 4'b0000}) + DIV_W'(den_abs[DEN_W-1:1]);
  assign div_neg  = (!w_sel[W_W-1] && (w_sel != '0)) != det_q[DET_W-1];

  // One quotient bit per cycle, restoring
  logic [DEN_W:0]   div_shift;
  logic [DEN_W+1:0] div_trial;
  assign div_shift = {rem_q, qd_q[DIV_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, den_q};

  // Quotient to Q16.16 with sign and clip
  logic              q_big, div_clip;
  logic [X_W-1:0]    div_val;
  always_comb begin
    q_big = |qd_q[DIV_W-1:X_W-1];
    if (neg_q) begin
      // exactly 2^31 still fits as the most negative value
      div_clip = (|qd_q[DIV_W-1:X_W]) || (qd_q[X_W-1] && (|qd_q[X_W-2:0]));
      div_val  = div_clip ? 32'h8000_0000 : X_W'(-qd_q[X_W-1:0]);
    end else begin
      div_clip = q_big;
      div_val  = div_clip ? 32'h7fff_ffff : qd_q[X_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= req_type_i;
      u0_q   <= u_first_i;
      u1_q   <= u_second_i;
      dt_q   <= dt_i;
      clip_q <= 1'b0;
      sing_q <= 1'b0;
      y_q    <= '{default: '0};
      xn_q   <= '{default: '0};
    end
    case (state_q)
      S_MUL: prod_q <= mul_res;
      S_ACC: acc_q <= acc_d;
      S_FIN: begin
        case (phase_q)
          PH_Y0: begin
            y_q[0] <= y_sat[X_W-1:0];
            clip_q <= clip_q | y_sat[X_W];
          end
          PH_Y1: begin
            y_q[1] <= y_sat[X_W-1:0];
            clip_q <= clip_q | y_sat[X_W];
          end
          PH_XD0, PH_XD1: xd_q <= acc_q[XD_W-1:0];
          PH_INC0, PH_INC1: begin
            xn_q[inc_row] <= x_sat[X_W-1:0];
            clip_q        <= clip_q | x_sat[X_W];
          end
          PH_DET: begin
            det_q  <= acc_q[DET_W-1:0];
            sing_q <= (acc_q == '0);
          end
          PH_V0: v_q[0] <= acc_q[V_W-1:0];
          PH_V1: v_q[1] <= acc_q[V_W-1:0];
          PH_W0: w_q[0] <= acc_q[W_W-1:0];
          default: w_q[1] <= acc_q[W_W-1:0];
        endcase
      end
      S_DSTART: begin
        qd_q  <= dividend;
        rem_q <= '0;
        den_q <= den_abs[DEN_W-1:0];
        neg_q <= div_neg;
      end
      S_DIV: begin
        if (!div_trial[DEN_W+1]) begin
          rem_q <= div_trial[DEN_W-1:0];
          qd_q  <= {qd_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= div_shift[DEN_W-1:0];
          qd_q  <= {qd_q[DIV_W-2:0], 1'b0};
        end
      end
      S_DFIN: begin
        xn_q[row_q] <= div_val;
        clip_q      <= clip_q | div_clip;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer, configuration, state vector and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_Y0;
      term_q      <= '0;
      row_q       <= 1'b0;
      cnt_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
      x_q         <= '{default: '0};
      out_valid_q <= 1'b0;
      yo_q        <= '{default: '0};
      xo_q        <= '{default: '0};
      st_q        <= ST_OK;
    end else begin
      // Register writes; an index past the last register is dropped
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_A:   a_q <= cfg_data_i;
          CFG_B:   b_q <= cfg_data_i;
          CFG_C:   c_q <= cfg_data_i;
          CFG_D:   d_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Raise valid when a result loads, drop it once the beat is taken
      if (load_out) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            term_q  <= '0;
            row_q   <= 1'b0;
            phase_q <= (req_type_i == REQ_INIT) ? PH_DET : PH_Y0;
            // a one-input model has no steady state to solve: state clears
            if ((req_type_i == REQ_INIT) && (NUM_INPUTS != 2)) state_q <= S_DONE;
            else state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (term_q == last_term) begin
            state_q <= S_FIN;
          end else begin
            term_q  <= term_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          term_q  <= '0;
          state_q <= S_MUL;
          unique case (phase_q)
            PH_Y0:   phase_q <= PH_Y1;
            PH_Y1:   phase_q <= PH_XD0;
            PH_XD0:  phase_q <= PH_INC0;
            PH_INC0: phase_q <= PH_XD1;
            PH_XD1:  phase_q <= PH_INC1;
            PH_INC1: state_q <= S_DONE;
            PH_DET: begin
              // singular A: skip the solve, state stays cleared
              if (acc_q == '0) state_q <= S_DONE;
              else phase_q <= PH_V0;
            end
            PH_V0:   phase_q <= PH_V1;
            PH_V1:   phase_q <= PH_W0;
            PH_W0:   phase_q <= PH_W1;
            default: begin
              row_q   <= 1'b0;
              state_q <= S_DSTART;
            end
          endcase
        end
        S_DSTART: begin
          cnt_q   <= CNT_W'(DIV_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) state_q <= S_DFIN;
          else cnt_q <= cnt_q - CNT_W'(1);
        end
        S_DFIN: begin
          if (!row_q) begin
            row_q   <= 1'b1;
            state_q <= S_DSTART;
          end else begin
            state_q <= S_DONE;
          end
        end
        default: begin
          // S_DONE: hold until the result register is free, then commit x
          if (out_free) begin
            yo_q        <= y_q;
            xo_q        <= xn_q;
            x_q         <= xn_q;
            if (sing_q) st_q <= ST_SINGULAR;
            else if (clip_q) st_q <= ST_SATURATED;
            else st_q <= ST_OK;
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_first_o   = yo_q[0];
  assign y_second_o  = yo_q[1];
  assign x_first_o   = xo_q[0];
  assign x_second_o  = xo_q[1];
  assign status_o    = st_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted beat keeps the request side stalled while the sequencer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request side not stalled after accept");

  // The state vector and the delivered state agree after every result load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (x_q[0] == x_first_o) && (x_q[1] == x_second_o))
    else $error("state vector and result state differ");

  // A singular init delivers a cleared state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_SINGULAR)) |-> (x_first_o == '0) && (x_second_o == '0))
    else $error("singular result with nonzero state");

  // The divider only runs for an init beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (req_q == REQ_INIT))
    else $error("divider active on a step beat");

endmodule
